[hw/rtl/tct_pkg.sv]
package tct_pkg;

  localparam int LOC_W  = 11;
  localparam int CELL_W = 16;
  localparam int IDX_W  = 11;

  localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
  localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
  localparam logic [7:0] CHAR_SPACE     = 8'h20;
  localparam logic [7:0] ATTR_RESET     = 8'h0F;

  localparam logic [1:0] ADDR_TEXT_ATTRIBUTE = 2'd0;

  typedef enum logic [1:0] {
    CMD_PUT,
    CMD_MOVE,
    CMD_CLEAR,
    CMD_READ
  } tct_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COPY,
    ST_FILL,
    ST_READ
  } tct_state_t;

  typedef struct packed {
    tct_cmd_t          command;
    logic [7:0]        char_code;
    logic signed [7:0] move_step;
    logic              move_horizontal;
    logic [IDX_W-1:0]  cell_index;
  } tct_request_t;

  typedef struct packed {
    logic [LOC_W-1:0]  cursor_location;
    logic [CELL_W-1:0] cell_value;
  } tct_result_t;

endpackage

[hw/rtl/text_console_terminal_core.sv]
// Put, newline and cursor moves without a scroll never raise busy, so the next item may
// follow at once; a read holds busy through ST_READ. The single port pair of the cell
// memory sets the rest: a scroll copies the lower rows up and blanks the last row, a clear
// blanks every cell, and a backspace copies each cell right of the cursor one place left and
// blanks the last cell, all one cell at a time. Reset homes the cursor and restores the
// attribute; screen contents stay unknown until a clear command.
module text_console_terminal_core #(
  parameter int SCREEN_ROWS = 25,
  parameter int SCREEN_COLS = 80
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  tct_pkg::tct_request_t request,
  output logic                  busy,
  output logic                  done,
  output tct_pkg::tct_result_t  result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [1:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  import tct_pkg::*;

  localparam int CELL_TOTAL = SCREEN_ROWS * SCREEN_COLS;
  localparam int ADDR_W     = $clog2(CELL_TOTAL);

  logic [7:0]        text_attribute;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [CELL_W-1:0] mem_rdata;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_attribute <= ATTR_RESET;
    end else if (psel && penable && pwrite && paddr == ADDR_TEXT_ATTRIBUTE) begin
      text_attribute <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_TEXT_ATTRIBUTE) begin
      prdata = {24'b0, text_attribute};
    end
  end

  tct_seq #(
    .SCREEN_ROWS (SCREEN_ROWS),
    .SCREEN_COLS (SCREEN_COLS)
  ) u_seq (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .request        (request),
    .text_attribute (text_attribute),
    .busy           (busy),
    .done           (done),
    .result         (result),
    .mem_we         (mem_we),
    .mem_waddr      (mem_waddr),
    .mem_wdata      (mem_wdata),
    .mem_raddr      (mem_raddr),
    .mem_rdata      (mem_rdata)
  );

  tct_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_TOTAL)
  ) u_cells (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Every result strobe answers an accepted item or ends a multi-cycle command.
  a_done_has_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) || $past(start && !busy)))
    else $error("result strobe without an item in flight");

  // Leaving a multi-cycle command always delivers its result.
  a_busy_end_delivers: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("busy dropped without a result");

  // Clear and read never finish in the accepting cycle.
  a_multi_cycle_cmds: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (request.command == CMD_CLEAR || request.command == CMD_READ))
      |=> busy)
    else $error("clear or read did not hold busy");

endmodule

[hw/rtl/tct_ram.sv]
module tct_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/tct_seq.sv]
module tct_seq #(
  parameter int SCREEN_ROWS = 25,
  parameter int SCREEN_COLS = 80,
  localparam int ADDR_W = $clog2(SCREEN_ROWS * SCREEN_COLS)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  tct_pkg::tct_request_t     request,
  input  logic [7:0]                text_attribute,
  output logic                      busy,
  output logic                      done,
  output tct_pkg::tct_result_t      result,
  output logic                      mem_we,
  output logic [ADDR_W-1:0]         mem_waddr,
  output logic [tct_pkg::CELL_W-1:0] mem_wdata,
  output logic [ADDR_W-1:0]         mem_raddr,
  input  logic [tct_pkg::CELL_W-1:0] mem_rdata
);

  import tct_pkg::*;

  localparam int CELL_TOTAL = SCREEN_ROWS * SCREEN_COLS;
  localparam int COL_W  = $clog2(SCREEN_COLS);
  localparam int ROW_W  = $clog2(SCREEN_ROWS);
  localparam int CR_W   = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int MAG_W  = (CR_W > 8) ? CR_W : 8;
  localparam int SUM_W  = MAG_W + 2;
  localparam int LFULL_W = (ADDR_W > LOC_W) ? ADDR_W : LOC_W;
  localparam int IEXT_W = ((ADDR_W > IDX_W) ? ADDR_W : IDX_W) + 1;

  localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELL_TOTAL - 1);
  localparam logic [ADDR_W-1:0] LAST_ROW0  = ADDR_W'((SCREEN_ROWS - 1) * SCREEN_COLS);
  localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(SCREEN_COLS);
  localparam logic [ADDR_W-1:0] ADDR_ONE   = ADDR_W'(1);
  localparam logic signed [SUM_W-1:0] COL_MAX_S = SUM_W'(SCREEN_COLS - 1);
  localparam logic signed [SUM_W-1:0] ROWS_S    = SUM_W'(SCREEN_ROWS);
  localparam logic signed [SUM_W-1:0] ROW_MAX_S = SUM_W'(SCREEN_ROWS - 1);
  localparam logic signed [SUM_W-1:0] ONE_S     = SUM_W'(1);

  tct_state_t state, state_next;

  logic [COL_W-1:0]  cur_col, col_next;
  logic [ROW_W-1:0]  cur_row, row_next;
  logic [ADDR_W-1:0] src, src_next;
  logic [ADDR_W-1:0] gap, gap_next;
  logic [ADDR_W-1:0] fill_addr, fill_addr_next;
  logic              pend, pend_next;
  logic [ADDR_W-1:0] pend_addr, pend_addr_next;
  logic              read_ok, read_ok_next;
  logic              emit;
  logic [CELL_W-1:0] cell_next;

  logic [ADDR_W-1:0]        pos;
  logic [CELL_W-1:0]        blank;
  logic signed [SUM_W-1:0]  col_s, row_s, step_s;
  logic signed [SUM_W-1:0]  fix_c, fix_r, c1, r1;
  logic                     scroll;
  logic [COL_W-1:0]         fix_col;
  logic [ROW_W-1:0]         fix_row;
  logic [IEXT_W-1:0]        idx_ext;
  logic                     idx_in_range;
  logic [LFULL_W-1:0]       loc_full;

  assign blank   = {text_attribute, CHAR_SPACE};
  assign pos     = ADDR_W'(ADDR_W'(cur_row) * ROW_STRIDE + ADDR_W'(cur_col));
  assign col_s   = {{(SUM_W - COL_W){1'b0}}, cur_col};
  assign row_s   = {{(SUM_W - ROW_W){1'b0}}, cur_row};
  assign step_s  = {{(SUM_W - 8){request.move_step[7]}}, request.move_step};
  assign idx_ext = {{(IEXT_W - IDX_W){1'b0}}, request.cell_index};
  assign idx_in_range = idx_ext < IEXT_W'(CELL_TOTAL);
  assign busy    = (state != ST_IDLE);

  // Proposed cursor for each command, before wrap and clamp.
  always_comb begin
    fix_c = col_s;
    fix_r = row_s;
    case (request.command)
      CMD_PUT: begin
        if (request.char_code == CHAR_NEWLINE) begin
          fix_c = '0;
          fix_r = row_s + ONE_S;
        end else if (request.char_code == CHAR_BACKSPACE) begin
          fix_c = col_s - ONE_S;
        end else begin
          fix_c = col_s + ONE_S;
        end
      end
      CMD_MOVE: begin
        if (request.move_horizontal) begin
          fix_c = col_s + step_s;
        end else begin
          fix_r = row_s + step_s;
        end
      end
      CMD_CLEAR: begin
        fix_c = '0;
        fix_r = '0;
      end
      default: begin
        fix_c = col_s;
        fix_r = row_s;
      end
    endcase
  end

  // Wrap and clamp; a row past the bottom pins to the last row and asks for a scroll.
  always_comb begin
    c1 = fix_c;
    r1 = fix_r;
    if (c1 < 0) begin
      if (r1 > 0) begin
        c1 = COL_MAX_S;
        r1 = r1 - ONE_S;
      end else begin
        c1 = '0;
      end
    end
    if (r1 < 0) begin
      r1 = '0;
    end
    if (c1 > COL_MAX_S) begin
      c1 = '0;
      r1 = r1 + ONE_S;
    end
    scroll = (r1 >= ROWS_S);
    if (scroll) begin
      r1 = ROW_MAX_S;
    end
    fix_col = c1[COL_W-1:0];
    fix_row = r1[ROW_W-1:0];
  end

  always_comb begin
    state_next     = state;
    col_next       = cur_col;
    row_next       = cur_row;
    src_next       = src;
    gap_next       = gap;
    fill_addr_next = fill_addr;
    pend_next      = 1'b0;
    pend_addr_next = pend_addr;
    read_ok_next   = read_ok;
    emit           = 1'b0;
    cell_next      = '0;
    mem_we         = 1'b0;
    mem_waddr      = pend_addr;
    mem_wdata      = mem_rdata;
    mem_raddr      = src;

    // A copied cell is written in the cycle after its read; this write wins the port.
    if (pend) begin
      mem_we    = 1'b1;
      mem_waddr = pend_addr;
      mem_wdata = mem_rdata;
    end

    case (state)
      ST_IDLE: begin
        if (start) begin
          case (request.command)
            CMD_PUT: begin
              col_next = fix_col;
              row_next = fix_row;
              if (request.char_code == CHAR_BACKSPACE) begin
                if (pos != '0) begin
                  mem_we    = 1'b1;
                  mem_waddr = pos - ADDR_ONE;
                  mem_wdata = blank;
                end
                fill_addr_next = LAST_CELL;
                if (pos == LAST_CELL) begin
                  state_next = ST_FILL;
                end else begin
                  src_next   = pos + ADDR_ONE;
                  gap_next   = ADDR_ONE;
                  state_next = ST_COPY;
                end
              end else begin
                if (request.char_code != CHAR_NEWLINE) begin
                  mem_we    = 1'b1;
                  mem_waddr = pos;
                  mem_wdata = {text_attribute, request.char_code};
                end
                if (scroll) begin
                  src_next       = ROW_STRIDE;
                  gap_next       = ROW_STRIDE;
                  fill_addr_next = LAST_ROW0;
                  state_next     = ST_COPY;
                end else begin
                  emit = 1'b1;
                end
              end
            end
            CMD_MOVE: begin
              col_next = fix_col;
              row_next = fix_row;
              if (scroll) begin
                src_next       = ROW_STRIDE;
                gap_next       = ROW_STRIDE;
                fill_addr_next = LAST_ROW0;
                state_next     = ST_COPY;
              end else begin
                emit = 1'b1;
              end
            end
            CMD_CLEAR: begin
              col_next       = '0;
              row_next       = '0;
              fill_addr_next = '0;
              state_next     = ST_FILL;
            end
            default: begin
              mem_raddr    = idx_ext[ADDR_W-1:0];
              read_ok_next = idx_in_range;
              state_next   = ST_READ;
            end
          endcase
        end
      end
      ST_COPY: begin
        // Reads run ahead of writes, so a cell is never read after being overwritten.
        mem_raddr      = src;
        pend_next      = 1'b1;
        pend_addr_next = src - gap;
        if (src == LAST_CELL) begin
          state_next = ST_FILL;
        end else begin
          src_next = src + ADDR_ONE;
        end
      end
      ST_FILL: begin
        if (!pend) begin
          mem_we    = 1'b1;
          mem_waddr = fill_addr;
          mem_wdata = blank;
          if (fill_addr == LAST_CELL) begin
            emit       = 1'b1;
            state_next = ST_IDLE;
          end else begin
            fill_addr_next = fill_addr + ADDR_ONE;
          end
        end
      end
      ST_READ: begin
        emit       = 1'b1;
        cell_next  = read_ok ? mem_rdata : '0;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign loc_full = LFULL_W'(row_next) * LFULL_W'(SCREEN_COLS) + LFULL_W'(col_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      cur_col <= '0;
      cur_row <= '0;
      pend    <= 1'b0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      cur_col <= col_next;
      cur_row <= row_next;
      pend    <= pend_next;
      done    <= emit;
    end
  end

  always_ff @(posedge clk) begin
    src       <= src_next;
    gap       <= gap_next;
    fill_addr <= fill_addr_next;
    pend_addr <= pend_addr_next;
    read_ok   <= read_ok_next;
    if (emit) begin
      result.cursor_location <= loc_full[LOC_W-1:0];
      result.cell_value      <= cell_next;
    end
  end

endmodule

[test/text_console_terminal_core_test.sv]
module text_console_terminal_core_test;
  import tct_pkg::*;

  localparam int ROWS = 25;
  localparam int COLS = 80;
  localparam int CELL_COUNT = ROWS * COLS;
  localparam int STALL_LIMIT = 10000;

  // Tracks the screen, cursor and attribute, and keeps the results still owed by the block.
  class console_tracker;
    logic [CELL_W-1:0] cells [CELL_COUNT];
    int col;
    int row;
    logic [7:0] attribute;
    tct_result_t awaited_results[$];
    int errors;
    int checked;
    int scrolls;
    int command_count[4];

    function new();
      foreach (cells[i]) cells[i] = '0;
      col = 0;
      row = 0;
      attribute = ATTR_RESET;
    endfunction

    function logic [CELL_W-1:0] blank();
      return {attribute, CHAR_SPACE};
    endfunction

    function void scroll();
      for (int i = 0; i < (ROWS - 1) * COLS; i++) cells[i] = cells[i + COLS];
      for (int i = (ROWS - 1) * COLS; i < CELL_COUNT; i++) cells[i] = blank();
      row = ROWS - 1;
      scrolls++;
    endfunction

    function void settle_cursor();
      if (col < 0) begin
        if (row > 0) begin
          col = COLS - 1;
          row--;
        end else begin
          col = 0;
        end
      end
      if (row < 0) row = 0;
      if (col > COLS - 1) begin
        col = 0;
        row++;
      end
      if (row >= ROWS) scroll();
    endfunction

    function void accept_command(tct_request_t r);
      int pos;
      logic [CELL_W-1:0] cell_out;
      tct_result_t exp_result;
      pos = row * COLS + col;
      cell_out = '0;
      command_count[r.command]++;
      case (r.command)
        CMD_PUT: begin
          if (r.char_code == CHAR_NEWLINE) begin
            row++;
            col = 0;
          end else if (r.char_code == CHAR_BACKSPACE) begin
            for (int i = pos; i < CELL_COUNT - 1; i++) cells[i] = cells[i + 1];
            cells[CELL_COUNT - 1] = blank();
            // At the very first cell there is no previous cell to blank.
            if (pos > 0) cells[pos - 1] = blank();
            col--;
          end else begin
            cells[pos] = {attribute, r.char_code};
            col++;
          end
          settle_cursor();
        end
        CMD_MOVE: begin
          if (r.move_horizontal) col += int'($signed(r.move_step));
          else row += int'($signed(r.move_step));
          settle_cursor();
        end
        CMD_CLEAR: begin
          foreach (cells[i]) cells[i] = blank();
          col = 0;
          row = 0;
        end
        CMD_READ: begin
          if (r.cell_index < CELL_COUNT) cell_out = cells[r.cell_index];
        end
      endcase
      exp_result.cursor_location = LOC_W'(row * COLS + col);
      exp_result.cell_value = cell_out;
      awaited_results.push_back(exp_result);
    endfunction

    function void check_result(tct_result_t got);
      tct_result_t exp_result;
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got location %0d cell %h",
                 $time, got.cursor_location, got.cell_value);
        errors++;
        return;
      end
      exp_result = awaited_results.pop_front();
      checked++;
      if (got.cursor_location !== exp_result.cursor_location) begin
        $display("%0t: cursor_location expected %0d, got %0d",
                 $time, exp_result.cursor_location, got.cursor_location);
        errors++;
      end
      if (got.cell_value !== exp_result.cell_value) begin
        $display("%0t: cell_value expected %h, got %h",
                 $time, exp_result.cell_value, got.cell_value);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  tct_request_t request = '0;
  logic busy;
  logic done;
  tct_result_t result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  console_tracker board = new();
  int idle_cycles = 0;
  int settings_used = 0;

  text_console_terminal_core #(
    .SCREEN_ROWS(ROWS),
    .SCREEN_COLS(COLS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .request(request),
    .busy(busy),
    .done(done),
    .result(result),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && done) board.check_result(result);
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("text_console_terminal_core_test: errors");
      $finish;
    end
  end

  function automatic tct_request_t make_request(tct_cmd_t cmd, logic [7:0] ch, int step,
                                                bit horiz, int idx);
    tct_request_t r;
    r.command = cmd;
    r.char_code = ch;
    r.move_step = 8'(step);
    r.move_horizontal = horiz;
    r.cell_index = IDX_W'(idx);
    return r;
  endfunction

  function automatic tct_request_t random_request();
    tct_request_t r;
    int roll;
    r = make_request(CMD_PUT, 8'($urandom_range(0, 255)), $urandom_range(0, 255),
                     1'($urandom_range(0, 1)), $urandom_range(0, 2047));
    roll = $urandom_range(0, 99);
    if (roll < 45) begin
      r.command = CMD_PUT;
    end else if (roll < 50) begin
      r.command = CMD_PUT;
      r.char_code = CHAR_NEWLINE;
    end else if (roll < 56) begin
      r.command = CMD_PUT;
      r.char_code = CHAR_BACKSPACE;
    end else if (roll < 76) begin
      r.command = CMD_MOVE;
      // Small steps move the cursor a short way; the full range of steps exercises the wrap and clamp.
      if ($urandom_range(0, 1)) r.move_step = 8'(int'($urandom_range(0, 6)) - 3);
    end else if (roll < 78) begin
      r.command = CMD_CLEAR;
    end else begin
      r.command = CMD_READ;
      if ($urandom_range(0, 9) != 0) r.cell_index = IDX_W'($urandom_range(0, CELL_COUNT - 1));
      else r.cell_index = IDX_W'($urandom_range(CELL_COUNT, 2047));
    end
    return r;
  endfunction

  task automatic send(tct_request_t r);
    start <= 1'b1;
    request <= r;
    do @(posedge clk); while (busy);
    board.accept_command(r);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (board.awaited_results.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic write_attribute(logic [7:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_TEXT_ATTRIBUTE;
    pwdata <= {24'h0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    board.attribute = value;
    settings_used++;
    @(posedge clk);
  endtask

  task automatic check_attribute();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_TEXT_ATTRIBUTE;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[7:0] !== board.attribute) begin
      $display("%0t: text_attribute readback expected %h, got %h",
               $time, board.attribute, prdata[7:0]);
      board.errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_random(int count, bit gaps);
    tct_request_t r;
    for (int n = 0; n < count; n++) begin
      r = random_request();
      send(r);
      if ($urandom_range(0, 199) == 0) begin
        drain();
      end else if (gaps && $urandom_range(0, 99) < 33) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  endtask

  initial begin
    tct_request_t plan[$];
    logic [7:0] phase_attribute [4];

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    check_attribute();
    write_attribute(8'hFF);
    check_attribute();

    // The screen holds nothing defined until it is cleared.
    plan.push_back(make_request(CMD_CLEAR, 8'h00, 0, 1'b0, 0));
    plan.push_back(make_request(CMD_PUT, 8'h41, 0, 1'b0, 0));
    plan.push_back(make_request(CMD_PUT, 8'h00, 0, 1'b0, 0));
    plan.push_back(make_request(CMD_PUT, 8'hFF, 0, 1'b0, 0));
    plan.push_back(make_request(CMD_READ, 8'h00, 0, 1'b0, 0));
    plan.push_back(make_request(CMD_READ, 8'h00, 0, 1'b0, 2));
    plan.push_back(make_request(CMD_PUT, CHAR_BACKSPACE, 0, 1'b0, 0));
    plan.push_back(make_request(CMD_MOVE, 8'h00, -128, 1'b1, 0));
    plan.push_back(make_request(CMD_PUT, CHAR_BACKSPACE, 0, 1'b0, 0));
    plan.push_back(make_request(CMD_READ, 8'h00, 0, 1'b0, 0));
    plan.push_back(make_request(CMD_PUT, CHAR_NEWLINE, 0, 1'b0, 0));
    plan.push_back(make_request(CMD_PUT, CHAR_BACKSPACE, 0, 1'b0, 0));
    plan.push_back(make_request(CMD_MOVE, 8'h00, 127, 1'b0, 0));
    plan.push_back(make_request(CMD_READ, 8'h00, 0, 1'b0, 1999));
    plan.push_back(make_request(CMD_MOVE, 8'h00, 127, 1'b1, 0));
    plan.push_back(make_request(CMD_MOVE, 8'h00, 79, 1'b1, 0));
    plan.push_back(make_request(CMD_PUT, 8'h5A, 0, 1'b0, 0));
    plan.push_back(make_request(CMD_PUT, CHAR_NEWLINE, 0, 1'b0, 0));
    plan.push_back(make_request(CMD_MOVE, 8'h00, -128, 1'b0, 0));
    plan.push_back(make_request(CMD_MOVE, 8'h00, 0, 1'b1, 0));
    plan.push_back(make_request(CMD_MOVE, 8'h00, 0, 1'b0, 0));
    plan.push_back(make_request(CMD_READ, 8'h00, 0, 1'b0, 80));
    plan.push_back(make_request(CMD_READ, 8'h00, 0, 1'b0, 1999));
    plan.push_back(make_request(CMD_READ, 8'h00, 0, 1'b0, 2000));
    plan.push_back(make_request(CMD_READ, 8'h00, 0, 1'b0, 2047));
    foreach (plan[i]) send(plan[i]);
    drain();

    phase_attribute[0] = 8'h00;
    phase_attribute[1] = 8'($urandom_range(1, 254));
    phase_attribute[2] = 8'hFF;
    phase_attribute[3] = 8'($urandom_range(0, 255));
    for (int p = 0; p < 4; p++) begin
      write_attribute(phase_attribute[p]);
      check_attribute();
      // The third phase runs back to back to keep the block fully loaded.
      run_random(500, p != 2);
      drain();
    end

    repeat (2100) @(posedge clk);
    board.errors += board.awaited_results.size();

    $display("Ran %0d puts, %0d moves, %0d clears and %0d reads, with %0d scrolls.",
             board.command_count[CMD_PUT], board.command_count[CMD_MOVE],
             board.command_count[CMD_CLEAR], board.command_count[CMD_READ], board.scrolls);
    $display("Checked %0d results over %0d attribute settings.",
             board.checked, settings_used + 1);
    if (board.errors == 0) begin
      $display("text_console_terminal_core_test: clean");
    end else begin
      $display("text_console_terminal_core_test: errors");
    end
    $finish;
  end

endmodule
